### design/mrs_pkg.sv
package mrs_pkg;

  // Width of the saturating tick counter and of the timed-phase registers.
  localparam int unsigned TickBits = 16;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TickBits-1:0] TickMax  = {TickBits{1'b1}};
  localparam logic [DutyW-1:0]    MaxDuty  = 7'd100;
  localparam logic [DutyW-1:0]    SpeedInc = 7'd5;

  // Reset values of the configuration registers.
  localparam logic [9:0]       BrakeTicksRst  = 10'd10;
  localparam logic [DutyW-1:0] RampStepRst    = 7'd5;
  localparam logic [TimeW-1:0] HomFwdTicksRst = 16'd50;
  localparam logic [TimeW-1:0] ClnRev1Rst     = 16'd50;
  localparam logic [TimeW-1:0] ClnRev2Rst     = 16'd150;
  localparam logic [TimeW-1:0] ClnFwd2Rst     = 16'd20;
  localparam logic [3:0]       RetryLimitRst  = 4'd1;
  localparam logic [DutyW-1:0] InitSpeedRst   = 7'd50;

  // Limit switch groups that end a phase.
  localparam logic [3:0] HitsHome = 4'h5;
  localparam logic [3:0] HitsDump = 4'hA;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRAKE_TICKS = 3'd0,
    CFG_RAMP_STEP   = 3'd1,
    CFG_HOM_FWD     = 3'd2,
    CFG_CLN_REV1    = 3'd3,
    CFG_CLN_REV2    = 3'd4,
    CFG_CLN_FWD2    = 3'd5,
    CFG_RETRY_LIMIT = 3'd6,
    CFG_INIT_SPEED  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_FWD    = 4'd1,
    CMD_REV    = 4'd2,
    CMD_BRAKE  = 4'd3,
    CMD_COAST  = 4'd4,
    CMD_HOME   = 4'd5,
    CMD_CLEAN  = 4'd6,
    CMD_STOP   = 4'd7,
    CMD_FASTER = 4'd8,
    CMD_SLOWER = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    BR_COAST = 2'd0,
    BR_BRAKE = 2'd1,
    BR_FWD   = 2'd2,
    BR_REV   = 2'd3
  } bridge_e;

  // Motor phase machine, one-hot.
  typedef enum logic [6:0] {
    MP_IDLE   = 7'b0000001,
    MP_FWD    = 7'b0000010,
    MP_REV    = 7'b0000100,
    MP_FWD_ST = 7'b0001000,
    MP_REV_ST = 7'b0010000,
    MP_BRAKE  = 7'b0100000,
    MP_COAST  = 7'b1000000
  } mp_e;

  // Action sequencer, one-hot.
  typedef enum logic [6:0] {
    AP_IDLE     = 7'b0000001,
    AP_STOP     = 7'b0000010,
    AP_HOM_REV  = 7'b0000100,
    AP_HOM_FWD  = 7'b0001000,
    AP_CLN_FWD  = 7'b0010000,
    AP_CLN_REV  = 7'b0100000,
    AP_CLN_FWD2 = 7'b1000000
  } ap_e;

  // Reported code of a motor phase.
  function automatic logic [2:0] mp_code(input mp_e ph);
    logic [2:0] c;
    case (ph)
      MP_IDLE:   c = 3'd0;
      MP_FWD:    c = 3'd1;
      MP_REV:    c = 3'd2;
      MP_FWD_ST: c = 3'd3;
      MP_REV_ST: c = 3'd4;
      MP_BRAKE:  c = 3'd5;
      MP_COAST:  c = 3'd6;
      default:   c = 3'd0;
    endcase
    return c;
  endfunction

  // Reported code of an action phase.
  function automatic logic [2:0] ap_code(input ap_e ph);
    logic [2:0] c;
    case (ph)
      AP_IDLE:     c = 3'd0;
      AP_STOP:     c = 3'd1;
      AP_HOM_REV:  c = 3'd2;
      AP_HOM_FWD:  c = 3'd3;
      AP_CLN_FWD:  c = 3'd4;
      AP_CLN_REV:  c = 3'd5;
      AP_CLN_FWD2: c = 3'd6;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

### design/mrs_if.sv
// Tick channel: one command and the limit switch hits per transfer.
interface mrs_in_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               cmd;
  logic [3:0]               limit_hits;

  modport source (output valid, cmd, limit_hits, input ready);
  modport sink   (input valid, cmd, limit_hits, output ready);
endinterface

// Result channel: bridge drive and phase status after each tick.
interface mrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 bridge_mode;
  logic [mrs_pkg::DutyW-1:0]  duty;
  logic [2:0]                 motor_phase;
  logic [2:0]                 action_phase;
  logic                       busy_res;
  logic                       rejected;

  modport source (output valid, bridge_mode, duty, motor_phase, action_phase, busy_res,
                  rejected, input ready);
  modport sink   (input valid, bridge_mode, duty, motor_phase, action_phase, busy_res,
                  rejected, output ready);
endinterface

### design/motor_ramp_sequencer.sv
// Motor ramp sequencer: H-bridge phase machine with a homing/cleaning action sequencer.
//
// in_i carries one control tick per transfer (cmd, limit_hits). For every accepted
// tick exactly one result transfer appears on out_o, with the bridge mode, the
// applied duty and the phase codes after that tick, plus the busy and rejected flags.
// The configuration port writes register cfg_idx_i with cfg_data_i at any edge with
// cfg_we_i high; the user must use it only while no tick is in flight (not enforced).
//
// A tick and its result pass through registers: the tick waits in the input
// register, and the whole tick update is one combinational pass into the
// state and result registers. Throughput is one tick per cycle while out_o takes results.
// A result waiting on a stalled receiver holds in the output register while the
// input register still takes one more tick; further ticks stall on in_i.ready.
//
// Reset (rst_ni low, asynchronous) clears both stages, returns the motor to idle
// with the bridge coasting, the action sequencer to idle, and loads all
// configuration registers with their defaults; target speed starts at 50.
module motor_ramp_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mrs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mrs_pkg::CfgDataW-1:0]   cfg_data_i,
  mrs_in_if.sink                         in_i,
  mrs_out_if.source                      out_o
);

  // Configuration registers.
  logic [9:0]                      brake_ticks_q;
  logic [mrs_pkg::DutyW-1:0]       ramp_step_q;
  logic [mrs_pkg::TimeW-1:0]       hom_fwd_q, cln_rev1_q, cln_rev2_q, cln_fwd2_q;
  logic [3:0]                      retry_limit_q;

  // Input stage.
  logic                            in_valid_q;
  logic [3:0]                      in_cmd_q;
  logic [3:0]                      in_hits_q;

  // Machine state.
  mrs_pkg::mp_e                    mp_q, mp_d;
  mrs_pkg::ap_e                    ap_q, ap_d;
  mrs_pkg::mp_e                    pend_q, pend_d;
  mrs_pkg::bridge_e                br_q, br_d;
  logic [mrs_pkg::TickBits-1:0]    tick_q, tick_d;
  logic [mrs_pkg::DutyW-1:0]       duty_q, duty_d;
  logic [mrs_pkg::DutyW-1:0]       tgt_q, tgt_d;
  logic [3:0]                      retry_q, retry_d;
  logic                            rej_d;

  // Output stage.
  logic                            out_valid_q;
  logic [1:0]                      out_br_q;
  logic [mrs_pkg::DutyW-1:0]       out_duty_q;
  logic [2:0]                      out_mp_q, out_ap_q;
  logic                            out_busy_q, out_rej_q;

  logic                            fire;
  logic [mrs_pkg::DutyW-1:0]       init_clamped;

  // Handshake: the update pass runs when the output register is free or draining.
  assign fire        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || fire;

  assign init_clamped = (cfg_data_i[mrs_pkg::DutyW-1:0] > mrs_pkg::MaxDuty)
                        ? mrs_pkg::MaxDuty : cfg_data_i[mrs_pkg::DutyW-1:0];

  // One tick of the action sequencer and motor phase machine.
  always_comb begin
    logic                          go_home, go_clean, stop;
    mrs_pkg::mp_e                  nxt;
    logic [mrs_pkg::DutyW:0]       tsum, dsum, tpls;
    logic [mrs_pkg::DutyW-1:0]     step;
    logic                          fwd, starting, reached;
    logic [31:0]                   tick_w;

    go_home  = 1'b0;
    go_clean = 1'b0;
    stop     = 1'b0;
    rej_d    = 1'b0;
    reached  = 1'b0;
    pend_d   = pend_q;
    tgt_d    = tgt_q;
    ap_d     = ap_q;
    mp_d     = mp_q;
    duty_d   = duty_q;
    br_d     = br_q;
    retry_d  = retry_q;
    tick_d   = (tick_q == mrs_pkg::TickMax) ? tick_q : tick_q + 1'b1;
    tick_w   = 32'(tick_d);
    tsum     = {1'b0, tgt_q} + {1'b0, mrs_pkg::SpeedInc};

    // Command decode; unknown codes do nothing.
    case (in_cmd_q)
      mrs_pkg::CMD_FWD:   pend_d = mrs_pkg::MP_FWD;
      mrs_pkg::CMD_REV:   pend_d = mrs_pkg::MP_REV;
      mrs_pkg::CMD_BRAKE: pend_d = mrs_pkg::MP_BRAKE;
      mrs_pkg::CMD_COAST: pend_d = mrs_pkg::MP_COAST;
      mrs_pkg::CMD_HOME: begin
        if (ap_q != mrs_pkg::AP_IDLE) rej_d = 1'b1;
        else go_home = 1'b1;
      end
      mrs_pkg::CMD_CLEAN: begin
        if (ap_q != mrs_pkg::AP_IDLE) rej_d = 1'b1;
        else go_clean = 1'b1;
      end
      mrs_pkg::CMD_STOP: stop = 1'b1;
      mrs_pkg::CMD_FASTER, mrs_pkg::CMD_SLOWER: begin
        if (in_cmd_q == mrs_pkg::CMD_FASTER) begin
          tgt_d = (tsum > {1'b0, mrs_pkg::MaxDuty}) ? mrs_pkg::MaxDuty
                                                    : tsum[mrs_pkg::DutyW-1:0];
        end else begin
          tgt_d = (tgt_q >= mrs_pkg::SpeedInc) ? tgt_q - mrs_pkg::SpeedInc : '0;
        end
        if (mp_q == mrs_pkg::MP_FWD) pend_d = mrs_pkg::MP_FWD_ST;
        else if (mp_q == mrs_pkg::MP_REV) pend_d = mrs_pkg::MP_REV_ST;
      end
      default: ;
    endcase

    // Action sequencer.
    nxt = pend_d;
    if (stop) begin
      ap_d = mrs_pkg::AP_STOP;
      nxt  = mrs_pkg::MP_COAST;
    end
    case (ap_d)
      mrs_pkg::AP_IDLE: begin
        if (go_home) begin
          ap_d   = mrs_pkg::AP_HOM_REV;
          pend_d = mrs_pkg::MP_REV;
          nxt    = mrs_pkg::MP_REV;
        end
        if (go_clean) begin
          ap_d    = mrs_pkg::AP_CLN_FWD;
          retry_d = '0;
          pend_d  = mrs_pkg::MP_FWD;
          nxt     = mrs_pkg::MP_FWD;
        end
      end
      mrs_pkg::AP_HOM_REV: begin
        if ((in_hits_q & mrs_pkg::HitsHome) != '0) begin
          ap_d   = mrs_pkg::AP_HOM_FWD;
          pend_d = mrs_pkg::MP_FWD;
          nxt    = mrs_pkg::MP_FWD;
        end
      end
      mrs_pkg::AP_HOM_FWD: begin
        if (mp_q == mrs_pkg::MP_FWD && tick_w >= 32'(hom_fwd_q)) begin
          ap_d = mrs_pkg::AP_STOP;
          nxt  = mrs_pkg::MP_COAST;
        end
      end
      mrs_pkg::AP_CLN_FWD: begin
        if ((in_hits_q & mrs_pkg::HitsDump) != '0) begin
          ap_d   = mrs_pkg::AP_CLN_REV;
          pend_d = mrs_pkg::MP_REV;
          nxt    = mrs_pkg::MP_REV;
        end
      end
      mrs_pkg::AP_CLN_REV: begin
        if (retry_q < retry_limit_q) begin
          if (mp_q == mrs_pkg::MP_REV && tick_w >= 32'(cln_rev1_q)) begin
            ap_d    = mrs_pkg::AP_CLN_FWD;
            pend_d  = mrs_pkg::MP_FWD;
            nxt     = mrs_pkg::MP_FWD;
            retry_d = retry_q + 1'b1;
          end
        end else if ((mp_q == mrs_pkg::MP_REV && tick_w >= 32'(cln_rev2_q)) ||
                     ((in_hits_q & mrs_pkg::HitsHome) != '0)) begin
          ap_d    = mrs_pkg::AP_CLN_FWD2;
          pend_d  = mrs_pkg::MP_FWD;
          nxt     = mrs_pkg::MP_FWD;
          retry_d = '0;
        end
      end
      mrs_pkg::AP_CLN_FWD2: begin
        if (mp_q == mrs_pkg::MP_FWD && tick_w >= 32'(cln_fwd2_q)) begin
          ap_d = mrs_pkg::AP_STOP;
          nxt  = mrs_pkg::MP_COAST;
        end
      end
      mrs_pkg::AP_STOP: begin
        if (mp_q == mrs_pkg::MP_IDLE) begin
          ap_d = mrs_pkg::AP_IDLE;
          nxt  = mrs_pkg::MP_IDLE;
        end
      end
      default: ;
    endcase

    // Soft-start ramp toward the target; a zero step counts as one.
    step = (ramp_step_q == '0) ? 7'd1 : ramp_step_q;
    tpls = {1'b0, tgt_d} + {1'b0, step};
    dsum = {1'b0, duty_q} + {1'b0, step};
    fwd      = (mp_q == mrs_pkg::MP_FWD_ST) || (mp_q == mrs_pkg::MP_FWD);
    starting = (mp_q == mrs_pkg::MP_FWD_ST) || (mp_q == mrs_pkg::MP_REV_ST);

    // Motor phase machine.
    case (mp_q)
      mrs_pkg::MP_IDLE: begin
        if (nxt == mrs_pkg::MP_FWD || nxt == mrs_pkg::MP_REV) begin
          duty_d = '0;
          tick_d = '0;
          mp_d   = (nxt == mrs_pkg::MP_FWD) ? mrs_pkg::MP_FWD_ST : mrs_pkg::MP_REV_ST;
          br_d   = (nxt == mrs_pkg::MP_FWD) ? mrs_pkg::BR_FWD : mrs_pkg::BR_REV;
        end
        pend_d = mrs_pkg::MP_IDLE;
      end
      mrs_pkg::MP_FWD_ST, mrs_pkg::MP_REV_ST, mrs_pkg::MP_FWD, mrs_pkg::MP_REV: begin
        if (nxt == mrs_pkg::MP_BRAKE) begin
          mp_d   = mrs_pkg::MP_BRAKE;
          br_d   = mrs_pkg::BR_BRAKE;
          tick_d = '0;
          pend_d = mrs_pkg::MP_IDLE;
        end else if (nxt == mrs_pkg::MP_COAST) begin
          mp_d   = mrs_pkg::MP_COAST;
          br_d   = mrs_pkg::BR_COAST;
          tick_d = '0;
          pend_d = mrs_pkg::MP_IDLE;
        end else if (nxt == (fwd ? mrs_pkg::MP_REV : mrs_pkg::MP_FWD)) begin
          // Direction change: coast first, keep the new direction pending.
          mp_d   = mrs_pkg::MP_COAST;
          br_d   = mrs_pkg::BR_COAST;
          tick_d = '0;
        end else if (starting) begin
          if ({1'b0, duty_q} > tpls) begin
            duty_d = duty_q - step;
          end else if (dsum < {1'b0, tgt_d}) begin
            duty_d = dsum[mrs_pkg::DutyW-1:0];
          end else begin
            duty_d  = tgt_d;
            reached = 1'b1;
          end
          if (reached) mp_d = fwd ? mrs_pkg::MP_FWD : mrs_pkg::MP_REV;
          pend_d = mrs_pkg::MP_IDLE;
        end else begin
          if (nxt == (fwd ? mrs_pkg::MP_FWD_ST : mrs_pkg::MP_REV_ST)) mp_d = nxt;
          pend_d = mrs_pkg::MP_IDLE;
        end
      end
      mrs_pkg::MP_BRAKE, mrs_pkg::MP_COAST: begin
        if (tick_w >= 32'(brake_ticks_q)) begin
          mp_d   = mrs_pkg::MP_IDLE;
          br_d   = mrs_pkg::BR_COAST;
          tick_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Configuration registers; the initial speed only loads the target.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_ticks_q <= mrs_pkg::BrakeTicksRst;
      ramp_step_q   <= mrs_pkg::RampStepRst;
      hom_fwd_q     <= mrs_pkg::HomFwdTicksRst;
      cln_rev1_q    <= mrs_pkg::ClnRev1Rst;
      cln_rev2_q    <= mrs_pkg::ClnRev2Rst;
      cln_fwd2_q    <= mrs_pkg::ClnFwd2Rst;
      retry_limit_q <= mrs_pkg::RetryLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrs_pkg::CFG_BRAKE_TICKS: brake_ticks_q <= cfg_data_i[9:0];
        mrs_pkg::CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[mrs_pkg::DutyW-1:0];
        mrs_pkg::CFG_HOM_FWD:     hom_fwd_q     <= cfg_data_i;
        mrs_pkg::CFG_CLN_REV1:    cln_rev1_q    <= cfg_data_i;
        mrs_pkg::CFG_CLN_REV2:    cln_rev2_q    <= cfg_data_i;
        mrs_pkg::CFG_CLN_FWD2:    cln_fwd2_q    <= cfg_data_i;
        mrs_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q  <= in_i.cmd;
      in_hits_q <= in_i.limit_hits;
    end
  end

  // Machine state; a write of the initial speed also loads the target.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q    <= mrs_pkg::MP_IDLE;
      ap_q    <= mrs_pkg::AP_IDLE;
      pend_q  <= mrs_pkg::MP_IDLE;
      br_q    <= mrs_pkg::BR_COAST;
      tick_q  <= '0;
      duty_q  <= '0;
      tgt_q   <= mrs_pkg::InitSpeedRst;
      retry_q <= '0;
    end else begin
      if (fire) begin
        mp_q    <= mp_d;
        ap_q    <= ap_d;
        pend_q  <= pend_d;
        br_q    <= br_d;
        tick_q  <= tick_d;
        duty_q  <= duty_d;
        tgt_q   <= tgt_d;
        retry_q <= retry_d;
      end
      if (cfg_we_i && cfg_idx_i == mrs_pkg::CFG_INIT_SPEED) begin
        tgt_q <= init_clamped;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_br_q   <= br_d;
      out_duty_q <= (br_d == mrs_pkg::BR_FWD || br_d == mrs_pkg::BR_REV) ? duty_d : '0;
      out_mp_q   <= mrs_pkg::mp_code(mp_d);
      out_ap_q   <= mrs_pkg::ap_code(ap_d);
      out_busy_q <= (ap_d != mrs_pkg::AP_IDLE);
      out_rej_q  <= rej_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bridge_mode  = out_br_q;
  assign out_o.duty         = out_duty_q;
  assign out_o.motor_phase  = out_mp_q;
  assign out_o.action_phase = out_ap_q;
  assign out_o.busy_res     = out_busy_q;
  assign out_o.rejected     = out_rej_q;

`ifndef SYNTHESIS
  // The phase registers stay one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(mp_q) && $onehot(ap_q))
    else $error("phase register lost its one-hot code");

  // A tick held in the input register is not dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_cmd_q) && $stable(in_hits_q))
    else $error("stalled tick was lost");

  // Drive duty is reported only while the bridge drives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_duty_q != '0 |->
      (out_br_q == mrs_pkg::BR_FWD || out_br_q == mrs_pkg::BR_REV))
    else $error("nonzero duty while braking or coasting");

  // Busy follows the reported action phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_busy_q == (out_ap_q != mrs_pkg::ap_code(mrs_pkg::AP_IDLE)))
    else $error("busy flag disagrees with action phase");
`endif

endmodule
